[hdl/ppb_pkg.sv]
`timescale 1ns / 1ps
package ppb_pkg;
  localparam logic [15:0] CH_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_SCALAR = 4'd3,
    MODE_MAX = 4'd4, MODE_MIN = 4'd5, MODE_INVERT = 4'd6, MODE_LERP = 4'd7,
    MODE_CLAMP = 4'd8, MODE_ROVER = 4'd9, MODE_CSCREEN = 4'd10, MODE_OVER = 4'd11,
    MODE_MULTIPLY = 4'd12, MODE_SCREEN = 4'd13, MODE_DARKEN = 4'd14,
    MODE_LIGHTEN = 4'd15
  } mode_t;

  typedef logic [15:0] chan_t;
  typedef chan_t [3:0] pix_t;

  // mode, both pixels and equality flag of one pair; index 0..3 = red, green, blue, alpha
  typedef struct packed {
    mode_t mode;
    pix_t  l;
    pix_t  r;
    logic  eq;
  } base_t;

  function automatic chan_t sat_add(input chan_t a, input chan_t b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? CH_MAX : s[15:0];
  endfunction

  function automatic chan_t sat_sub(input chan_t a, input chan_t b);
    return (a > b) ? chan_t'(a - b) : '0;
  endfunction

  function automatic chan_t umax(input chan_t a, input chan_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic chan_t umin(input chan_t a, input chan_t b);
    return (a < b) ? a : b;
  endfunction

  // rounding step of the normalized multiply on a registered product
  function automatic chan_t norm_round(input logic [31:0] p);
    logic [32:0] x;
    logic [33:0] y;
    x = {1'b0, p} + 33'h8000;
    y = {1'b0, x} + {18'd0, x[31:16]};
    return y[31:16];
  endfunction
endpackage

[hdl/premultiplied_pixel_blend_unit.sv]
`timescale 1ns / 1ps
// channel | valid    | stall     | payload
// input   | in_valid | in_stall  | mode, left_*, right_*, blend_weight, scale_factor
// result  | out_valid| out_stall | out_red/green/blue/alpha, pixels_equal
//
// one pixel pair per cycle unless stalled; stages multiply, round, combine
// the multipliers set the stage split: product register then rounding register
// a stall freezes every stage at once; in_stall follows out_stall while a result waits
// rst_n clears only the valid bits
module premultiplied_pixel_blend_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [15:0] in_left_red,
  input  logic [15:0] in_left_green,
  input  logic [15:0] in_left_blue,
  input  logic [15:0] in_left_alpha,
  input  logic [15:0] in_right_red,
  input  logic [15:0] in_right_green,
  input  logic [15:0] in_right_blue,
  input  logic [15:0] in_right_alpha,
  input  logic [16:0] in_blend_weight,
  input  logic [15:0] in_scale_factor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  output logic        out_pixels_equal
);
  import ppb_pkg::*;

  logic  [2:0] v_r;
  logic        en;
  base_t       b0, b1_r, b2_r;
  pix_t        l, r;
  logic [16:0] t;

  // per channel products: lr, sl (k*L), rl (~La*R), lrinv (~Ra*L),
  // cs (R*~L), sc (L*~R), dl (Ra*L), dr (La*R)
  logic [31:0] p_lr [4], p_sl [4], p_rl [4], p_lri [4];
  logic [31:0] p_cs [4], p_sc [4], p_dl [4], p_dr [4];
  logic [31:0] p_aa, p_al;
  pix_t m_lr_r, m_sl_r, m_rl_r, m_lri_r, m_cs_r, m_sc_r, m_dl_r, m_dr_r;
  chan_t m_aa_r, m_al_r;
  pix_t lerp_o, lerp_r;
  pix_t res, res_r;
  logic eq_r;

  assign en       = !(v_r[2] && out_stall);
  assign in_stall = !en;

  always_comb begin
    l = {in_left_alpha, in_left_blue, in_left_green, in_left_red};
    r = {in_right_alpha, in_right_blue, in_right_green, in_right_red};
    t = (in_blend_weight > 17'h10000) ? 17'h10000 : in_blend_weight;
    b0.mode = mode_t'(in_mode);
    b0.l = l;
    b0.r = r;
    b0.eq = (l == r);
  end

  for (genvar i = 0; i < 4; i++) begin : g_ch
    ppb_mul16 u_lr  (.clk, .en, .a(l[i]), .b(r[i]),             .prod_r(p_lr[i]));
    ppb_mul16 u_sl  (.clk, .en, .a(l[i]), .b(in_scale_factor),  .prod_r(p_sl[i]));
    ppb_mul16 u_rl  (.clk, .en, .a(r[i]), .b(~in_left_alpha),   .prod_r(p_rl[i]));
    ppb_mul16 u_lri (.clk, .en, .a(l[i]), .b(~in_right_alpha),  .prod_r(p_lri[i]));
    ppb_mul16 u_cs  (.clk, .en, .a(r[i]), .b(~l[i]),            .prod_r(p_cs[i]));
    ppb_mul16 u_sc  (.clk, .en, .a(l[i]), .b(~r[i]),            .prod_r(p_sc[i]));
    ppb_mul16 u_dl  (.clk, .en, .a(l[i]), .b(in_right_alpha),   .prod_r(p_dl[i]));
    ppb_mul16 u_dr  (.clk, .en, .a(r[i]), .b(in_left_alpha),    .prod_r(p_dr[i]));
    ppb_lerp  u_lp  (.clk, .en, .a(l[i]), .b(r[i]), .t(t),      .res(lerp_o[i]));
  end
  ppb_mul16 u_aa (.clk, .en, .a(in_left_alpha), .b(in_right_alpha),  .prod_r(p_aa));
  ppb_mul16 u_al (.clk, .en, .a(in_left_alpha), .b(~in_right_alpha), .prod_r(p_al));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r <= b0;
      b2_r <= b1_r;
      lerp_r <= lerp_o;
      m_aa_r <= norm_round(p_aa);
      m_al_r <= norm_round(p_al);
      for (int i = 0; i < 4; i++) begin
        m_lr_r[i]  <= norm_round(p_lr[i]);
        m_sl_r[i]  <= norm_round(p_sl[i]);
        m_rl_r[i]  <= norm_round(p_rl[i]);
        m_lri_r[i] <= norm_round(p_lri[i]);
        m_cs_r[i]  <= norm_round(p_cs[i]);
        m_sc_r[i]  <= norm_round(p_sc[i]);
        m_dl_r[i]  <= norm_round(p_dl[i]);
        m_dr_r[i]  <= norm_round(p_dr[i]);
      end
      res_r <= res;
      eq_r  <= b2_r.eq;
    end
  end

  always_comb begin
    chan_t a, b, la, ra;
    la = b2_r.l[3];
    ra = b2_r.r[3];
    res = '0;
    for (int i = 0; i < 4; i++) begin
      a = b2_r.l[i];
      b = b2_r.r[i];
      unique case (b2_r.mode)
        MODE_ADD:      res[i] = sat_add(a, b);
        MODE_SUB:      res[i] = sat_sub(a, b);
        MODE_MUL:      res[i] = m_lr_r[i];
        MODE_SCALAR:   res[i] = m_sl_r[i];
        MODE_MAX:      res[i] = umax(a, b);
        MODE_MIN:      res[i] = umin(a, b);
        MODE_INVERT:   res[i] = ~a;
        MODE_LERP:     res[i] = lerp_r[i];
        MODE_CLAMP:    res[i] = (i < 3) ? umin(a, la) : a;
        MODE_ROVER:    res[i] = sat_add(m_lri_r[i], b);
        MODE_CSCREEN:  res[i] = sat_add(a, m_cs_r[i]);
        MODE_OVER:     res[i] = sat_add(a, m_rl_r[i]);
        MODE_MULTIPLY: res[i] = (i == 3) ? chan_t'(la + ra - m_aa_r)
                              : sat_add(sat_add(m_lr_r[i], m_rl_r[i]), m_lri_r[i]);
        MODE_SCREEN:   res[i] = sat_add(b, m_sc_r[i]);
        MODE_DARKEN:   res[i] = (i == 3) ? chan_t'(ra + m_al_r)
                              : sat_add(sat_sub(umax(a, b), umax(m_dl_r[i], m_dr_r[i])),
                                        umin(a, b));
        MODE_LIGHTEN:  res[i] = (i == 3) ? chan_t'(ra + m_al_r)
                              : sat_add(sat_sub(umin(a, b), umin(m_dl_r[i], m_dr_r[i])),
                                        umax(a, b));
        default:       res[i] = '0;
      endcase
    end
  end

  assign out_valid        = v_r[2];
  assign out_red          = res_r[0];
  assign out_green        = res_r[1];
  assign out_blue         = res_r[2];
  assign out_alpha        = res_r[3];
  assign out_pixels_equal = eq_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> v_r[0] == $past(in_valid))
    else $error("valid bit lost at entry");
endmodule

[hdl/ppb_mul16.sv]
`timescale 1ns / 1ps
// 16x16 multiply with registered product; rounding to /65535 is done by ppb_pkg::norm_round
module ppb_mul16 (
  input  logic              clk,
  input  logic              en,
  input  ppb_pkg::chan_t    a,
  input  ppb_pkg::chan_t    b,
  output logic [31:0]       prod_r
);
  import ppb_pkg::*;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end
endmodule

[hdl/ppb_lerp.sv]
`timescale 1ns / 1ps
// one lerp channel: registered product, then combinational add with floored shift
module ppb_lerp (
  input  logic           clk,
  input  logic           en,
  input  ppb_pkg::chan_t a,
  input  ppb_pkg::chan_t b,
  input  logic [16:0]    t,
  output ppb_pkg::chan_t res
);
  import ppb_pkg::*;
  logic [32:0] prod_r;
  logic        neg_r;
  chan_t       a_r;
  chan_t       d;
  logic [33:0] q;

  always_comb begin
    d = (b >= a) ? chan_t'(b - a) : chan_t'(a - b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= d * t;
      neg_r  <= (b < a);
      a_r    <= a;
    end
  end

  always_comb begin
    q = {1'b0, prod_r} + (neg_r ? 34'hFFFF : 34'd0);
    res = neg_r ? chan_t'(a_r - q[31:16]) : chan_t'(a_r + q[31:16]);
  end
endmodule
